@@ rtl/fraction_lowest_terms_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the fraction reduction block
// Implication checks, same-cycle and next-cycle, with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef FRACTION_LOWEST_TERMS_TOP_ASSERT_SVH
`define FRACTION_LOWEST_TERMS_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define FLT_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define FLT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define FLT_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons)

`define FLT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

@@ rtl/flt_pkg.sv @@
// ----------------------------------------------------------------------------
// flt_pkg
// Types, word formats and the control store of the fraction reduction block.
// ----------------------------------------------------------------------------
`default_nettype none

package flt_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam int STEP_W     = 3;

  typedef logic [DATA_WIDTH-1:0] flt_mag_t;
  typedef logic [CNT_W-1:0]      flt_cnt_t;
  typedef logic [STEP_W-1:0]     flt_step_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] top_value;
    logic signed [DATA_WIDTH-1:0] bottom_value;
  } flt_in_t;

  typedef struct packed {
    logic                  is_negative;
    logic [DATA_WIDTH-1:0] reduced_top;
    logic [DATA_WIDTH-1:0] reduced_bottom;
    logic [DATA_WIDTH-1:0] common_divisor;
  } flt_out_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_GCD_TEST,
    OP_DIV_ITER,
    OP_QUOT_START,
    OP_EMIT
  } flt_op_t;

  typedef enum logic {
    SRC_TOP,
    SRC_BOT
  } flt_src_t;

  typedef enum logic [1:0] {
    DST_REM,
    DST_TOP,
    DST_BOT
  } flt_dst_t;

  typedef struct packed {
    flt_op_t   op;
    flt_src_t  src;
    flt_dst_t  dst;
    flt_step_t tgt;
  } flt_uword_t;

  localparam flt_step_t STEP_LOAD = 3'd0;
  localparam flt_step_t STEP_TEST = 3'd1;
  localparam flt_step_t STEP_REM  = 3'd2;
  localparam flt_step_t STEP_QTOP = 3'd3;
  localparam flt_step_t STEP_DTOP = 3'd4;
  localparam flt_step_t STEP_QBOT = 3'd5;
  localparam flt_step_t STEP_DBOT = 3'd6;
  localparam flt_step_t STEP_EMIT = 3'd7;

  function automatic flt_uword_t flt_ucode(input flt_step_t step);
    flt_uword_t uw;
    case (step)
      STEP_LOAD: uw = '{op: OP_LOAD,       src: SRC_TOP, dst: DST_REM, tgt: STEP_TEST};
      STEP_TEST: uw = '{op: OP_GCD_TEST,   src: SRC_TOP, dst: DST_REM, tgt: STEP_QTOP};
      STEP_REM:  uw = '{op: OP_DIV_ITER,   src: SRC_TOP, dst: DST_REM, tgt: STEP_TEST};
      STEP_QTOP: uw = '{op: OP_QUOT_START, src: SRC_TOP, dst: DST_TOP, tgt: STEP_EMIT};
      STEP_DTOP: uw = '{op: OP_DIV_ITER,   src: SRC_TOP, dst: DST_TOP, tgt: STEP_QBOT};
      STEP_QBOT: uw = '{op: OP_QUOT_START, src: SRC_BOT, dst: DST_BOT, tgt: STEP_EMIT};
      STEP_DBOT: uw = '{op: OP_DIV_ITER,   src: SRC_BOT, dst: DST_BOT, tgt: STEP_EMIT};
      default:   uw = '{op: OP_EMIT,       src: SRC_TOP, dst: DST_REM, tgt: STEP_LOAD};
    endcase
    return uw;
  endfunction

endpackage

`default_nettype wire

@@ rtl/fraction_lowest_terms_top.sv @@
// ----------------------------------------------------------------------------
// fraction_lowest_terms_top
// Reduces a signed fraction to lowest terms with Euclid's remainder method.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one word per fraction: signed
// numerator and denominator. Output channel out_valid/out_ready returns one
// word per fraction: sign, reduced magnitudes and the common divisor.
// A small control store steps a datapath built around one restoring divider
// that produces one quotient bit per cycle; it serves both the remainder
// rounds of the divisor search and the two final divisions.
// The time from input acceptance to out_valid grows with the number of
// remainder rounds (0 up to 43 for 32-bit values); the early-exit cases
// (a zero, a one or equal magnitudes) skip the rounds, and two zero inputs
// also skip the final divisions. One fraction is in work at a time; the next
// word can be taken in the cycle after a result enters the output register.
// The output register holds a result while the receiver stalls; the block
// finishes the next fraction meanwhile and holds at its final step until the
// register frees. Synchronous reset returns the sequencer to its load step
// and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fraction_lowest_terms_top_assert.svh"

module fraction_lowest_terms_top
  import flt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire flt_in_t  in_word,
  output logic          out_valid,
  input  wire logic     out_ready,
  output flt_out_t      out_word
);

  flt_step_t  step;
  flt_uword_t uw;

  logic     neg;
  flt_mag_t ma, mb, x, y, g, rt, rb;
  logic     rem_to_x;
  flt_mag_t dnum, drem, dden;
  flt_cnt_t dcnt;

  flt_mag_t                in_top_mag, in_bot_mag;
  logic [DATA_WIDTH:0]     shifted, diff;
  logic                    qbit;
  flt_mag_t                dnum_next, drem_next;
  logic                    out_free;

  assign uw       = flt_ucode(step);
  assign in_ready = (uw.op == OP_LOAD);
  assign out_free = !out_valid || out_ready;

  assign in_top_mag = in_word.top_value[DATA_WIDTH-1]
                    ? flt_mag_t'('0) - flt_mag_t'(in_word.top_value)
                    : flt_mag_t'(in_word.top_value);
  assign in_bot_mag = in_word.bottom_value[DATA_WIDTH-1]
                    ? flt_mag_t'('0) - flt_mag_t'(in_word.bottom_value)
                    : flt_mag_t'(in_word.bottom_value);

  always_comb begin
    shifted   = {drem, dnum[DATA_WIDTH-1]};
    diff      = shifted - {1'b0, dden};
    qbit      = !diff[DATA_WIDTH];
    drem_next = qbit ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
    dnum_next = {dnum[DATA_WIDTH-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_LOAD;
      out_valid <= 1'b0;
    end else begin
      if (uw.op == OP_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (uw.op)
        OP_LOAD: begin
          if (in_valid) begin
            neg  <= in_word.top_value[DATA_WIDTH-1] ^ in_word.bottom_value[DATA_WIDTH-1];
            ma   <= in_top_mag;
            mb   <= in_bot_mag;
            x    <= in_top_mag;
            y    <= in_bot_mag;
            step <= uw.tgt;
          end
        end
        OP_GCD_TEST: begin
          if (x == '0) begin
            g    <= y;
            step <= uw.tgt;
          end else if (y == '0) begin
            g    <= x;
            step <= uw.tgt;
          end else if (x == flt_mag_t'(1) || y == flt_mag_t'(1)) begin
            g    <= flt_mag_t'(1);
            step <= uw.tgt;
          end else if (x == y) begin
            g    <= x;
            step <= uw.tgt;
          end else begin
            rem_to_x <= (x > y);
            dnum     <= (x > y) ? x : y;
            dden     <= (x > y) ? y : x;
            drem     <= '0;
            dcnt     <= flt_cnt_t'(DATA_WIDTH - 1);
            step     <= step + flt_step_t'(1);
          end
        end
        OP_DIV_ITER: begin
          dnum <= dnum_next;
          drem <= drem_next;
          dcnt <= dcnt - flt_cnt_t'(1);
          if (dcnt == '0) begin
            case (uw.dst)
              DST_REM: begin
                if (rem_to_x) begin
                  x <= drem_next;
                end else begin
                  y <= drem_next;
                end
              end
              DST_TOP: rt <= dnum_next;
              default: rb <= dnum_next;
            endcase
            step <= uw.tgt;
          end
        end
        OP_QUOT_START: begin
          if (g == '0) begin
            rt   <= ma;
            rb   <= mb;
            step <= uw.tgt;
          end else begin
            dnum <= (uw.src == SRC_TOP) ? ma : mb;
            dden <= g;
            drem <= '0;
            dcnt <= flt_cnt_t'(DATA_WIDTH - 1);
            step <= step + flt_step_t'(1);
          end
        end
        OP_EMIT: begin
          if (out_free) begin
            out_word.is_negative    <= neg;
            out_word.reduced_top    <= rt;
            out_word.reduced_bottom <= rb;
            out_word.common_divisor <= g;
            step                    <= uw.tgt;
          end
        end
        default: step <= STEP_LOAD;
      endcase
    end
  end

  `FLT_ASSERT_IMPLY(a_div_nonzero, clk, rst, uw.op == OP_DIV_ITER, dden != '0)
  `FLT_ASSERT_NEXT(a_load_to_test, clk, rst, in_valid && in_ready, step == STEP_TEST)
  `FLT_ASSERT_IMPLY(a_zero_gcd_zero_terms, clk, rst,
                    out_valid && out_word.common_divisor == '0,
                    out_word.reduced_top == '0 && out_word.reduced_bottom == '0)

endmodule

`default_nettype wire
